>>> rtl/qfs_pkg.sv
// Shared types and constants for the quoted field splitter.
`default_nettype none

package qfs_pkg;

	localparam logic [7:0] QUOTE_BYTE = 8'h22;
	localparam logic [7:0] SEP_RESET  = 8'd44;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_TOO_MANY = 2'd2
	} err_t;

	// Classified input word handed from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_quote;
		logic       is_sep;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic [5:0] field_number;
		logic [7:0] char_position;
		logic       field_done;
		logic       record_done;
		logic [6:0] field_count;
		err_t       error_code;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/qfs_fifo.sv
// Small flop-based first-in first-out queue with full and empty flags.
`default_nettype none

module qfs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_rd) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_wr && !do_rd)      count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

>>> rtl/qfs_front.sv
// Front end: holds the separator register and classifies each incoming byte.
`default_nettype none

module qfs_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         push,
	input  wire logic         cmd_full,
	input  wire logic [7:0]   in_byte,
	input  wire logic         last_byte,
	output logic              cmd_push,
	output qfs_pkg::cmd_t     cmd
);
	import qfs_pkg::*;

	logic [7:0] sep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (cfg_we) begin
			sep_q <= cfg_data;
		end
	end

	assign cmd_push     = push && !cmd_full;
	assign cmd.data     = in_byte;
	assign cmd.last     = last_byte;
	assign cmd.is_quote = (in_byte == QUOTE_BYTE);
	assign cmd.is_sep   = (in_byte == sep_q);

endmodule

`default_nettype wire

>>> rtl/qfs_back.sv
// Back end: parser state, quote handling, error tracking and result forming.
`default_nettype none

module qfs_back #(
	parameter int MAX_FIELDS    = 64,
	parameter int MAX_FIELD_LEN = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire qfs_pkg::cmd_t  cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	input  wire logic           res_full,
	output logic                res_push,
	output qfs_pkg::result_t    res
);
	import qfs_pkg::*;

	localparam int FIW = $clog2(MAX_FIELDS);
	localparam int PW  = $clog2(MAX_FIELD_LEN + 1);
	localparam logic [PW-1:0]  LEN_LIM  = PW'(MAX_FIELD_LEN);
	localparam logic [FIW-1:0] IDX_LAST = FIW'(MAX_FIELDS - 1);

	logic           quotes_q, start_q;
	logic [FIW-1:0] idx_q;
	logic [PW-1:0]  pos_q;
	err_t           err_q;

	logic           quotes_n, start_n;
	logic [FIW-1:0] idx_n;
	logic [PW-1:0]  pos_n;
	err_t           err_n;
	logic           store;
	logic           fdone;
	logic           fire;
	logic [FIW-1:0] fnum;

	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;

	always_comb begin
		quotes_n = quotes_q;
		start_n  = start_q;
		idx_n    = idx_q;
		pos_n    = pos_q;
		err_n    = err_q;
		store    = 1'b0;
		fdone    = 1'b0;
		fnum     = '0;

		if (err_q == ERR_NONE) begin
			if (cmd.is_quote) quotes_n = !quotes_q;
			if (quotes_n) begin
				store   = !cmd.is_quote || !start_q;
				start_n = 1'b0;
			end else if (cmd.is_sep) begin
				if (idx_q == IDX_LAST) begin
					err_n = ERR_TOO_MANY;
				end else if (pos_q >= LEN_LIM) begin
					err_n = ERR_TOO_LONG;
				end else begin
					fdone   = 1'b1;
					fnum    = idx_q;
					idx_n   = idx_q + 1'b1;
					pos_n   = '0;
					start_n = 1'b1;
				end
			end else begin
				store   = !cmd.is_quote;
				start_n = 1'b0;
			end
			// Drop a character that has no room left in its field.
			if (store) begin
				if (pos_q >= LEN_LIM) begin
					err_n = ERR_TOO_LONG;
					store = 1'b0;
				end else begin
					fnum  = idx_q;
					pos_n = pos_q + 1'b1;
				end
			end
		end

		// Close the final field at record end.
		if (cmd.last) begin
			if (err_n == ERR_NONE && pos_n >= LEN_LIM) err_n = ERR_TOO_LONG;
			if (err_n == ERR_NONE) begin
				fdone = 1'b1;
				fnum  = idx_n;
			end
		end
	end

	always_comb begin
		res.out_char      = '0;
		res.char_valid    = 1'b0;
		res.field_number  = '0;
		res.char_position = '0;
		res.field_done    = 1'b0;
		res.field_count   = '0;
		res.record_done   = cmd.last;
		res.error_code    = err_n;
		if (err_n == ERR_NONE) begin
			res.out_char      = store ? cmd.data : 8'd0;
			res.char_valid    = store;
			res.field_number  = 6'(fnum);
			res.char_position = store ? 8'(pos_q) : 8'd0;
			res.field_done    = fdone;
			if (cmd.last) res.field_count = 7'({1'b0, idx_n} + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quotes_q <= 1'b0;
			start_q  <= 1'b1;
			idx_q    <= '0;
			pos_q    <= '0;
			err_q    <= ERR_NONE;
		end else if (fire) begin
			if (cmd.last) begin
				quotes_q <= 1'b0;
				start_q  <= 1'b1;
				idx_q    <= '0;
				pos_q    <= '0;
				err_q    <= ERR_NONE;
			end else begin
				quotes_q <= quotes_n;
				start_q  <= start_n;
				idx_q    <= idx_n;
				pos_q    <= pos_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/quoted_field_splitter.sv
// Top level of the quoted field splitter: front, word queue, back, result queue.
// Path: an accepted byte is written into the word queue; the back end reads it from the
//   queue head and writes its result word into the result queue, from which the
//   consumer pops it.
// Throughput: one byte per cycle while neither queue is full; the parser state is registered as each word is popped.
// Reset: arst_n clears the queues and parser state and sets the separator to ','.
`default_nettype none

module quoted_field_splitter #(
	parameter int MAX_FIELDS    = 64,
	parameter int MAX_FIELD_LEN = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_char,
	output logic            char_valid,
	output logic [5:0]      field_number,
	output logic [7:0]      char_position,
	output logic            field_done,
	output logic            record_done,
	output logic [6:0]      field_count,
	output logic [1:0]      error_code
);
	import qfs_pkg::*;

	localparam int CMD_W   = $bits(cmd_t);
	localparam int RES_W   = $bits(result_t);
	localparam int Q_DEPTH = 4;

	cmd_t    cmd_in, cmd_out;
	result_t res_in, res_out;
	logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic    res_push, res_full;
	logic [CMD_W-1:0] cmd_out_bits;
	logic [RES_W-1:0] res_out_bits;

	// Front: latch the separator and tag each byte as quote and/or separator.
	qfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.push      (push),
		.cmd_full  (cmd_full),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	assign full = cmd_full;

	// Word queue: decouple byte intake from the parser so each side can stall.
	qfs_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (Q_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out_bits),
		.empty   (cmd_empty)
	);

	assign cmd_out = cmd_t'(cmd_out_bits);

	// Back: advance the parser one word per cycle whenever a word is waiting and a result slot is free.
	qfs_back #(
		.MAX_FIELDS    (MAX_FIELDS),
		.MAX_FIELD_LEN (MAX_FIELD_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue: hold finished words until the consumer pops them.
	qfs_fifo #(
		.WIDTH (RES_W),
		.DEPTH (Q_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out_bits),
		.empty   (empty)
	);

	assign res_out       = result_t'(res_out_bits);
	assign out_char      = res_out.out_char;
	assign char_valid    = res_out.char_valid;
	assign field_number  = res_out.field_number;
	assign char_position = res_out.char_position;
	assign field_done    = res_out.field_done;
	assign record_done   = res_out.record_done;
	assign field_count   = res_out.field_count;
	assign error_code    = res_out.error_code;

endmodule

`default_nettype wire
